/* rtl/dll_pkg.sv */
// Shared types and constants for the bounded doubly linked list unit.
package dll_pkg;

  localparam int DATA_W     = 32;
  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd4;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value_out;
    logic [CNT_W-1:0]    count;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [IDX_W-1:0]  nxt;
    logic [IDX_W-1:0]  prv;
  } node_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    logic             we_val;
    logic             we_nxt;
    logic             we_prv;
    node_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic             take;
    logic [IDX_W-1:0] take_idx;
    logic             give;
    logic [IDX_W-1:0] give_idx;
  } fm_cmd_t;

endpackage

/* rtl/dll_node_ram.sv */
// Node storage: value, next link and previous link, one write and one read port.
module dll_node_ram (
  input  logic                    clk,
  input  dll_pkg::ram_wr_t        wr,
  input  logic                    rd_en,
  input  logic [dll_pkg::IDX_W-1:0] rd_addr,
  output dll_pkg::node_t          rd_data
);
  import dll_pkg::*;

  logic [DATA_W-1:0] val_mem [POOL_DEPTH];
  logic [IDX_W-1:0]  nxt_mem [POOL_DEPTH];
  logic [IDX_W-1:0]  prv_mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_val) begin
      val_mem[wr.addr] <= wr.data.val;
    end
    if (wr.we_nxt) begin
      nxt_mem[wr.addr] <= wr.data.nxt;
    end
    if (wr.we_prv) begin
      prv_mem[wr.addr] <= wr.data.prv;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.val <= val_mem[rd_addr];
      rd_data.nxt <= nxt_mem[rd_addr];
      rd_data.prv <= prv_mem[rd_addr];
    end
  end

endmodule

/* rtl/dll_free_map.sv */
// Free node map with lowest-free-node selection.
module dll_free_map (
  input  logic                      clk,
  input  logic                      rst,
  input  dll_pkg::fm_cmd_t          cmd,
  output logic                      free_any,
  output logic [dll_pkg::IDX_W-1:0] free_idx,
  output logic [dll_pkg::POOL_DEPTH-1:0] free_vec
);
  import dll_pkg::*;

  logic [POOL_DEPTH-1:0] free_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else begin
      if (cmd.take) begin
        free_map[cmd.take_idx] <= 1'b0;
      end
      if (cmd.give) begin
        free_map[cmd.give_idx] <= 1'b1;
      end
    end
  end

  // Lowest numbered free node wins.
  always_comb begin
    free_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign free_any = |free_map;
  assign free_vec = free_map;

endmodule

/* rtl/bounded_doubly_linked_list_unit.sv */
// Top level of the bounded doubly linked list unit: sequencer, list pointers and result register.
//
// The unit keeps a doubly linked list of up to 16 values in a fixed node pool and serves one
// transaction at a time: push at head or tail, pop from head or tail, test for a value, or
// delete the first node from the head that holds a value. Each request transaction returns
// exactly one response transaction carrying a status (ok or found, empty or not found, pool
// full), the value removed (zero otherwise) and the list length after the operation. A push
// takes the lowest numbered free node. A pop never has to repair a middle link, since it
// always takes the head or the tail. Contains and delete walk the list from the head through
// the single read port of the node memory, one node per cycle, with one shared value
// comparator judging each node, up to the list length; a delete that hits then unlinks the
// node, repairing the links of both neighbors when it lay in the middle of the list.
// The request side is ready only while the sequencer is idle; a finished response waits in
// its own register, so the next request is taken while the previous response is still
// unread. Node storage is not cleared at reset; the list never uses a node that a push has
// not written. Reset clears head, tail and length and marks every node free in the free map.
module bounded_doubly_linked_list_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dll_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dll_pkg::rsp_t rsp
);
  import dll_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_NEW,
    S_PUSH_LINK,
    S_SCAN,
    S_UNLINK,
    S_REPAIR,
    S_DONE
  } state_t;

  state_t state;

  // List registers.
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  node_count;

  // Registers of the transaction in progress.
  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   val_q;
  logic [IDX_W-1:0]    cur;
  logic [CNT_W-1:0]    step;
  logic [IDX_W-1:0]    new_idx;
  logic [IDX_W-1:0]    hit_nxt;
  logic [IDX_W-1:0]    hit_prv;
  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0]   res_val;

  // Memory and free map connections.
  ram_wr_t               ram_wr;
  logic                  ram_rd_en;
  logic [IDX_W-1:0]      ram_rd_addr;
  node_t                 ram_rd_data;
  fm_cmd_t               fm_cmd;
  logic                  free_any;
  logic [IDX_W-1:0]      free_idx;
  logic [POOL_DEPTH-1:0] free_vec;

  logic is_push;
  logic is_walk;
  logic is_pop_q;
  logic hit;
  logic is_middle;
  logic last_step;
  logic rsp_load;

  dll_node_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  dll_free_map u_free (
    .clk      (clk),
    .rst      (rst),
    .cmd      (fm_cmd),
    .free_any (free_any),
    .free_idx (free_idx),
    .free_vec (free_vec)
  );

  assign req_ready = (state == S_IDLE);

  assign is_push = (req.op == OP_PUSH_HEAD) || (req.op == OP_PUSH_TAIL);
  assign is_walk = (req.op == OP_POP_HEAD) || (req.op == OP_POP_TAIL) ||
                   (req.op == OP_CONTAINS) || (req.op == OP_DELETE);
  assign is_pop_q = (op_q == OP_POP_HEAD) || (op_q == OP_POP_TAIL);

  // The shared comparator: a pop always takes the node it fetched, a search needs a match.
  assign hit       = is_pop_q || (ram_rd_data.val == val_q);
  assign last_step = (step == node_count - CNT_W'(1));
  assign is_middle = (node_count > CNT_W'(1)) && (cur != head) && (cur != tail);

  // The finished result moves into the response register once that register is free.
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Memory port and free map control.
  always_comb begin
    ram_wr      = '0;
    fm_cmd      = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ram_rd_data.nxt;
    unique case (state)
      S_IDLE: begin
        // Fetch the first node on every idle cycle; harmless when no walk follows.
        ram_rd_en   = 1'b1;
        ram_rd_addr = (req.op == OP_POP_TAIL) ? tail : head;
      end
      S_SCAN: begin
        // Fetch the successor while the current node is being compared.
        ram_rd_en = 1'b1;
      end
      S_PUSH_NEW: begin
        ram_wr.addr     = new_idx;
        ram_wr.we_val   = 1'b1;
        ram_wr.we_nxt   = 1'b1;
        ram_wr.we_prv   = 1'b1;
        ram_wr.data.val = val_q;
        ram_wr.data.nxt = ((op_q == OP_PUSH_HEAD) && (node_count != '0)) ? head : '0;
        ram_wr.data.prv = ((op_q == OP_PUSH_TAIL) && (node_count != '0)) ? tail : '0;
        fm_cmd.take     = 1'b1;
        fm_cmd.take_idx = new_idx;
      end
      S_PUSH_LINK: begin
        if (op_q == OP_PUSH_HEAD) begin
          ram_wr.addr     = head;
          ram_wr.we_prv   = 1'b1;
          ram_wr.data.prv = new_idx;
        end else begin
          ram_wr.addr     = tail;
          ram_wr.we_nxt   = 1'b1;
          ram_wr.data.nxt = new_idx;
        end
      end
      S_UNLINK: begin
        if (is_middle) begin
          ram_wr.addr     = hit_prv;
          ram_wr.we_nxt   = 1'b1;
          ram_wr.data.nxt = hit_nxt;
        end else begin
          fm_cmd.give     = 1'b1;
          fm_cmd.give_idx = cur;
        end
      end
      S_REPAIR: begin
        ram_wr.addr     = hit_nxt;
        ram_wr.we_prv   = 1'b1;
        ram_wr.data.prv = hit_prv;
        fm_cmd.give     = 1'b1;
        fm_cmd.give_idx = cur;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, list registers and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      node_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q       <= req.op;
            val_q      <= req.value;
            res_status <= (is_push && !free_any) ? ST_FULL : ST_EMPTY;
            res_val    <= '0;
            cur        <= (req.op == OP_POP_TAIL) ? tail : head;
            step       <= '0;
            new_idx    <= free_idx;
            priority if (is_push) begin
              if (!free_any) begin
                state <= S_DONE;
              end else begin
                state <= S_PUSH_NEW;
              end
            end else if (is_walk && (node_count != '0)) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PUSH_NEW: begin
          if (node_count == '0) begin
            head       <= new_idx;
            tail       <= new_idx;
            node_count <= node_count + CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            state <= S_PUSH_LINK;
          end
        end
        S_PUSH_LINK: begin
          if (op_q == OP_PUSH_HEAD) begin
            head <= new_idx;
          end else begin
            tail <= new_idx;
          end
          node_count <= node_count + CNT_W'(1);
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            hit_nxt <= ram_rd_data.nxt;
            hit_prv <= ram_rd_data.prv;
            if (op_q == OP_CONTAINS) begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end else begin
              res_val <= ram_rd_data.val;
              state   <= S_UNLINK;
            end
          end else if (last_step) begin
            state <= S_DONE;
          end else begin
            cur  <= ram_rd_data.nxt;
            step <= step + CNT_W'(1);
          end
        end
        S_UNLINK: begin
          if (is_middle) begin
            state <= S_REPAIR;
          end else begin
            priority if (node_count <= CNT_W'(1)) begin
              head <= '0;
              tail <= '0;
            end else if (cur == head) begin
              head <= hit_nxt;
            end else begin
              tail <= hit_prv;
            end
            node_count <= node_count - CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_REPAIR: begin
          node_count <= node_count - CNT_W'(1);
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the response register is free.
          if (rsp_load) begin
            rsp.status    <= res_status;
            rsp.value_out <= res_val;
            rsp.count     <= node_count;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Between transactions the free map and the length must agree.
  a_free_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(free_vec) == POOL_DEPTH - int'(node_count)))
    else $error("free map disagrees with node count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    node_count <= CNT_W'(POOL_DEPTH))
    else $error("node count exceeds pool depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FULL)) |-> (rsp.count == CNT_W'(POOL_DEPTH)))
    else $error("pool full reported with free nodes left");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a transaction is in progress");

endmodule
